/* sv/per_class_queue_delay_averager_unit_macros.svh */
// assertion macros used by the pcqda_back rtl file
`ifndef PER_CLASS_QUEUE_DELAY_AVERAGER_UNIT_MACROS_SVH
`define PER_CLASS_QUEUE_DELAY_AVERAGER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PCQDA_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pcqda assertion failed");
`define PCQDA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pcqda assertion failed");
`else
`define PCQDA_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define PCQDA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* sv/pcqda_pkg.sv */
package pcqda_pkg;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_END   = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    localparam int OUT_W   = 40;
    localparam int SUM_W   = 48;
    localparam int COUNT_W = 16;

    localparam logic [OUT_W-1:0]   OUT_MAX   = {OUT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        op_t         op;
        logic [5:0]  traffic_class;
        logic [39:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic [39:0] average_delay;
        logic [39:0] sample_delay;
        logic [1:0]  status;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        op_t         op;
        logic [5:0]  traffic_class;
        logic        class_ok;
        logic [39:0] time_now;
    } work_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_TS,
        S_SW_RD,
        S_SW_DIV,
        S_SW_OUT
    } state_t;

endpackage

/* sv/pcqda_front.sv */
module pcqda_front #(
    parameter int NUM_CLASSES = 64,
    parameter int TIME_BITS   = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pcqda_pkg::in_item_t req,
    output logic                q_valid,
    output pcqda_pkg::work_t    q_item,
    input  logic                q_pop
);

    localparam logic [39:0] TIME_MASK =
        (TIME_BITS >= 40) ? {40{1'b1}} : ((40'd1 << (TIME_BITS % 40)) - 40'd1);

    pcqda_pkg::work_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push;
    pcqda_pkg::work_t work;

    always_comb
    begin
        work.op            = req.op;
        work.traffic_class = req.traffic_class;
        work.class_ok      = (32'(req.traffic_class) < NUM_CLASSES);
        work.time_now      = req.time_now & TIME_MASK;
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/pcqda_div.sv */
module pcqda_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pcqda_pkg::SUM_W-1:0]     dividend,
    input  logic [pcqda_pkg::COUNT_W-1:0]   divisor,
    output logic                            done,
    output logic [pcqda_pkg::SUM_W-1:0]     quotient
);

    localparam int SW = pcqda_pkg::SUM_W;
    localparam int CW = pcqda_pkg::COUNT_W;

    logic [CW-1:0]          rem_reg, rem_next;
    logic [SW-1:0]          quo_reg, quo_next;
    logic [CW-1:0]          dsr_reg, dsr_next;
    logic [$clog2(SW)-1:0]  step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW:0]            rem_sh;
    logic [CW:0]            trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[SW-1]};
        trial     = rem_sh - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[CW])
            begin
                rem_next = trial[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == ($clog2(SW))'(SW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/pcqda_back.sv */
`include "per_class_queue_delay_averager_unit_macros.svh"

module pcqda_back #(
    parameter int NUM_CLASSES = 64,
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  pcqda_pkg::work_t     q_item,
    output logic                 q_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output pcqda_pkg::out_item_t rsp
);

    localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int QD_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TS_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int TS_AW    = (TS_DEPTH > 1) ? $clog2(TS_DEPTH) : 1;
    localparam int SL_W     = FILL_W + 1;
    localparam int SUM_W    = pcqda_pkg::SUM_W;
    localparam int CNT_W    = pcqda_pkg::COUNT_W;
    localparam int OUT_W    = pcqda_pkg::OUT_W;
    localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

    // per-class record memories with one read and one write address, and a timestamp memory with one shared address
    logic [QD_W-1:0]   head_mem [NUM_CLASSES];
    logic [FILL_W-1:0] fill_mem [NUM_CLASSES];
    logic [SUM_W-1:0]  sum_mem  [NUM_CLASSES];
    logic [CNT_W-1:0]  cnt_mem  [NUM_CLASSES];
    logic [OUT_W-1:0]  avg_mem  [NUM_CLASSES];
    logic [OUT_W-1:0]  ts_mem   [TS_DEPTH];

    pcqda_pkg::state_t    state_reg, state_next;
    pcqda_pkg::work_t     item_reg, item_next;
    logic [CLS_W-1:0]     idx_reg, idx_next;
    logic [NUM_CLASSES-1:0] valid_reg;
    pcqda_pkg::out_item_t rsp_reg, out_item;
    logic                 rsp_valid_reg;

    logic [QD_W-1:0]   head_q;
    logic [FILL_W-1:0] fill_q;
    logic [SUM_W-1:0]  sum_q;
    logic [CNT_W-1:0]  cnt_q;
    logic [OUT_W-1:0]  avg_q;
    logic              rd_ok_reg;
    logic [OUT_W-1:0]  ts_q;

    logic [QD_W-1:0]   r_head;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [OUT_W-1:0]  r_avg;

    logic              rd_en, wr_en, ts_rd_en, ts_wr_en;
    logic [CLS_W-1:0]  rd_addr, wr_addr, item_cls;
    logic [QD_W-1:0]   w_head;
    logic [FILL_W-1:0] w_fill;
    logic [SUM_W-1:0]  w_sum;
    logic [CNT_W-1:0]  w_cnt;
    logic [OUT_W-1:0]  w_avg;
    logic [TS_AW-1:0]  ts_addr;
    logic [SL_W-1:0]   tail_sum;
    logic [QD_W-1:0]   tail_slot, head_inc;
    logic              out_free, out_load, div_start, div_done;
    logic [SUM_W-1:0]  div_quo;
    logic [OUT_W-1:0]  div_avg;

    logic [TIME_BITS-1:0] delay;
    logic [63:0]          delay64;
    logic [SUM_W:0]       sum_add;
    logic [SUM_W-1:0]     sum_new;
    logic [OUT_W-1:0]     sample;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign item_cls = item_reg.traffic_class[CLS_W-1:0];

    assign r_head = rd_ok_reg ? head_q : '0;
    assign r_fill = rd_ok_reg ? fill_q : '0;
    assign r_sum  = rd_ok_reg ? sum_q  : '0;
    assign r_cnt  = rd_ok_reg ? cnt_q  : '0;
    assign r_avg  = rd_ok_reg ? avg_q  : '0;

    // ring slot arithmetic, both operands stay below twice the depth
    always_comb
    begin
        tail_sum = SL_W'(r_head) + SL_W'(r_fill);
        if (tail_sum >= SL_W'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SL_W'(QUEUE_DEPTH);
        end
        tail_slot = QD_W'(tail_sum);
        head_inc  = (SL_W'(r_head) + 1'b1 == SL_W'(QUEUE_DEPTH)) ? '0 : r_head + 1'b1;
    end

    // delay modulo 2^TIME_BITS and saturating accumulate
    always_comb
    begin
        delay   = TIME_BITS'(item_reg.time_now) - TIME_BITS'(ts_q);
        delay64 = 64'(delay);
        sum_add = {1'b0, r_sum} + {1'b0, delay64[SUM_W-1:0]};
        sum_new = ((|delay64[63:SUM_W]) || sum_add[SUM_W]) ? pcqda_pkg::SUM_MAX
                                                           : sum_add[SUM_W-1:0];
        sample  = (|delay64[63:OUT_W]) ? pcqda_pkg::OUT_MAX : delay64[OUT_W-1:0];
        div_avg = (r_cnt == '0) ? '0
                : (|div_quo[SUM_W-1:OUT_W]) ? pcqda_pkg::OUT_MAX : div_quo[OUT_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcqda_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_item.op == pcqda_pkg::OP_END) ? pcqda_pkg::S_SW_RD
                                                                  : pcqda_pkg::S_RD;
                end
            end
            pcqda_pkg::S_RD:
            begin
                if (item_reg.op == pcqda_pkg::OP_DEQ && item_reg.class_ok && r_fill != '0)
                begin
                    state_next = pcqda_pkg::S_TS;
                end
                else if (out_free)
                begin
                    state_next = pcqda_pkg::S_IDLE;
                end
            end
            pcqda_pkg::S_TS:
            begin
                if (out_free)
                begin
                    state_next = pcqda_pkg::S_IDLE;
                end
            end
            pcqda_pkg::S_SW_RD:
            begin
                state_next = pcqda_pkg::S_SW_DIV;
            end
            pcqda_pkg::S_SW_DIV:
            begin
                if (div_done)
                begin
                    state_next = (idx_reg == LAST_CLS) ? pcqda_pkg::S_SW_OUT
                                                       : pcqda_pkg::S_SW_RD;
                end
            end
            pcqda_pkg::S_SW_OUT:
            begin
                if (out_free)
                begin
                    state_next = pcqda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pcqda_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        item_next = item_reg;
        idx_next  = idx_reg;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = item_cls;
        w_head    = r_head;
        w_fill    = r_fill;
        w_sum     = r_sum;
        w_cnt     = r_cnt;
        w_avg     = r_avg;
        ts_rd_en  = 1'b0;
        ts_wr_en  = 1'b0;
        ts_addr   = TS_AW'(item_cls) * TS_AW'(QUEUE_DEPTH) + TS_AW'(r_head);
        div_start = 1'b0;
        out_load  = 1'b0;
        out_item.average_delay = item_reg.class_ok ? r_avg : '0;
        out_item.sample_delay  = '0;
        out_item.status        = pcqda_pkg::STS_OK;
        case (state_reg)
            pcqda_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    idx_next  = '0;
                    rd_en     = 1'b1;
                    rd_addr   = (q_item.op == pcqda_pkg::OP_END) ? '0
                              : q_item.traffic_class[CLS_W-1:0];
                end
            end
            pcqda_pkg::S_RD:
            begin
                case (item_reg.op)
                    pcqda_pkg::OP_ENQ:
                    begin
                        if (!item_reg.class_ok || r_fill == FILL_W'(QUEUE_DEPTH))
                        begin
                            out_item.status = pcqda_pkg::STS_FULL;
                        end
                        else if (out_free)
                        begin
                            ts_wr_en = 1'b1;
                            ts_addr  = TS_AW'(item_cls) * TS_AW'(QUEUE_DEPTH)
                                     + TS_AW'(tail_slot);
                            wr_en    = 1'b1;
                            w_fill   = r_fill + 1'b1;
                        end
                        out_load = out_free;
                    end
                    pcqda_pkg::OP_DEQ:
                    begin
                        if (!item_reg.class_ok || r_fill == '0)
                        begin
                            out_item.status = pcqda_pkg::STS_EMPTY;
                            out_load        = out_free;
                        end
                        else
                        begin
                            ts_rd_en = 1'b1;
                        end
                    end
                    default:
                    begin
                        out_load = out_free;
                    end
                endcase
            end
            pcqda_pkg::S_TS:
            begin
                out_item.sample_delay = sample;
                if (out_free)
                begin
                    out_load = 1'b1;
                    wr_en    = 1'b1;
                    w_head   = head_inc;
                    w_fill   = r_fill - 1'b1;
                    w_sum    = sum_new;
                    w_cnt    = (r_cnt == pcqda_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
                end
            end
            pcqda_pkg::S_SW_RD:
            begin
                div_start = 1'b1;
            end
            pcqda_pkg::S_SW_DIV:
            begin
                if (div_done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    w_sum   = '0;
                    w_cnt   = '0;
                    w_avg   = div_avg;
                    if (idx_reg != LAST_CLS)
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            pcqda_pkg::S_SW_OUT:
            begin
                out_item.average_delay = '0;
                out_load               = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            head_q    <= head_mem[rd_addr];
            fill_q    <= fill_mem[rd_addr];
            sum_q     <= sum_mem[rd_addr];
            cnt_q     <= cnt_mem[rd_addr];
            avg_q     <= avg_mem[rd_addr];
            rd_ok_reg <= valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            head_mem[wr_addr] <= w_head;
            fill_mem[wr_addr] <= w_fill;
            sum_mem[wr_addr]  <= w_sum;
            cnt_mem[wr_addr]  <= w_cnt;
            avg_mem[wr_addr]  <= w_avg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ts_rd_en)
        begin
            ts_q <= ts_mem[ts_addr];
        end
        if (ts_wr_en)
        begin
            ts_mem[ts_addr] <= item_reg.time_now;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        if (out_load)
        begin
            rsp_reg <= out_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcqda_pkg::S_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    pcqda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (r_sum),
        .divisor  (r_cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PCQDA_ASSERT_IMPLY(a_ts_only_deq, clk, rst_n,
        state_reg == pcqda_pkg::S_TS, item_reg.op == pcqda_pkg::OP_DEQ)
    `PCQDA_ASSERT_IMPLY(a_fill_bound, clk, rst_n,
        state_reg == pcqda_pkg::S_RD, r_fill <= FILL_W'(QUEUE_DEPTH))
    `PCQDA_ASSERT_IMPLY(a_pop_idle, clk, rst_n,
        q_pop, state_reg == pcqda_pkg::S_IDLE && !wr_en)
    `PCQDA_ASSERT_NEXT(a_no_overwrite, clk, rst_n,
        rsp_valid_reg && !rsp_ready, rsp_valid_reg && $stable(rsp_reg))

endmodule

/* sv/per_class_queue_delay_averager_unit.sv */
// per-class queue delay averager
// request channel req_valid/req_ready carries op, traffic_class and time_now;
// response channel rsp_valid/rsp_ready returns one item per request with
// average_delay, sample_delay and status
// a two-entry input queue decouples acceptance from the execution engine
// enqueue, query and failed dequeue hold the engine in the idle and read
// states and load the response after the registered read of the per-class
// record memory; a successful dequeue adds a timestamp state, set by the
// registered read of the record memory and then the timestamp memory
// end of period walks every class through a bit-serial divider, one class
// after another, before its response is loaded
// reset empties all class queues and clears sums, counts and averages at once
// by per-class valid bits; no clearing pass is needed
// when the receiver stalls the response waits in its output register while
// the input queue keeps taking up to two more requests
module per_class_queue_delay_averager_unit #(
    parameter int NUM_CLASSES = 64,
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  pcqda_pkg::in_item_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output pcqda_pkg::out_item_t rsp
);

    logic             q_valid;
    logic             q_pop;
    pcqda_pkg::work_t q_item;

    pcqda_front #(
        .NUM_CLASSES (NUM_CLASSES),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    pcqda_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* dv/tb_per_class_queue_delay_averager_unit.sv */
`timescale 1ns / 100ps

module tb_per_class_queue_delay_averager_unit;

    localparam int N_CLASS = 64;
    localparam int DEPTH   = 16;

    class delay_scoreboard;
        logic [39:0] stamps [N_CLASS][$];
        logic [47:0] sum_by_class [N_CLASS];
        logic [15:0] count_by_class [N_CLASS];
        logic [39:0] avg_by_class [N_CLASS];
        pcqda_pkg::out_item_t pending [$];
        int          errors;

        function new();
            for (int c = 0; c < N_CLASS; c++)
            begin
                sum_by_class[c] = '0;
                count_by_class[c] = '0;
                avg_by_class[c] = '0;
            end
            errors = 0;
        endfunction

        function void note_request(pcqda_pkg::in_item_t it);
            pcqda_pkg::out_item_t o;
            logic [39:0] old_ts;
            logic [39:0] d;
            logic [48:0] s;
            int c;
            c = int'(it.traffic_class);
            o = '0;
            case (it.op)
                pcqda_pkg::OP_ENQ:
                begin
                    if (stamps[c].size() >= DEPTH)
                        o.status = pcqda_pkg::STS_FULL;
                    else
                        stamps[c].insert(stamps[c].size(), it.time_now);
                end
                pcqda_pkg::OP_DEQ:
                begin
                    if (stamps[c].size() == 0)
                        o.status = pcqda_pkg::STS_EMPTY;
                    else
                    begin
                        old_ts = stamps[c][0];
                        stamps[c].delete(0);
                        d = it.time_now - old_ts;
                        s = {1'b0, sum_by_class[c]} + d;
                        sum_by_class[c] = (s > pcqda_pkg::SUM_MAX) ? pcqda_pkg::SUM_MAX
                                                                   : s[47:0];
                        if (count_by_class[c] != pcqda_pkg::COUNT_MAX)
                            count_by_class[c]++;
                        o.sample_delay = d;
                    end
                end
                pcqda_pkg::OP_END:
                begin
                    for (int k = 0; k < N_CLASS; k++)
                    begin
                        if (count_by_class[k] == 0)
                            avg_by_class[k] = '0;
                        else
                            avg_by_class[k] = 40'(sum_by_class[k] / count_by_class[k]);
                        sum_by_class[k] = '0;
                        count_by_class[k] = '0;
                    end
                end
                default: ;
            endcase
            if (it.op != pcqda_pkg::OP_END)
                o.average_delay = avg_by_class[c];
            pending.insert(pending.size(), o);
        endfunction

        function void check_response(pcqda_pkg::out_item_t got);
            pcqda_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, got);
                errors++;
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (got.average_delay !== want.average_delay)
            begin
                $display("%0t: average_delay exp %h got %h", $time,
                    want.average_delay, got.average_delay);
                errors++;
            end
            if (got.sample_delay !== want.sample_delay)
            begin
                $display("%0t: sample_delay exp %h got %h", $time,
                    want.sample_delay, got.sample_delay);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    pcqda_pkg::in_item_t  req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    pcqda_pkg::out_item_t rsp;

    delay_scoreboard sb;
    logic [39:0] clock_us;
    int          stall_mode;

    per_class_queue_delay_averager_unit uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    task automatic send_item(pcqda_pkg::op_t op, logic [5:0] cls, logic [39:0] t);
        pcqda_pkg::in_item_t it;
        int gap;
        gap = (stall_mode == 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.op = op;
        it.traffic_class = cls;
        it.time_now = t;
        req <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(it);
    endtask

    // advance a local clock so delays look realistic, with occasional jumps
    function automatic logic [39:0] next_time();
        if ($urandom_range(0, 19) == 0)
            clock_us = 40'({$urandom, $urandom});
        else
            clock_us = clock_us + 40'($urandom_range(0, 5000));
        return clock_us;
    endfunction

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);

    // the receiver may stall before taking each response, but only when stall_mode is nonzero
    initial
    begin
        int wait_cycles;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = (stall_mode == 0) ? 0 : $urandom_range(0, 5);
            if (wait_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    initial
    begin
        #5000000;
        $display("tb_per_class_queue_delay_averager_unit: FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int c;
        sb = new();
        stall_mode = 0;
        clock_us = '0;
        req_valid = 1'b0;
        req = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dequeue, fill to full and overflow, extreme wrap delay, end of period and queries
        send_item(pcqda_pkg::OP_DEQ, 6'd0, 40'd5);
        send_item(pcqda_pkg::OP_QUERY, 6'd63, '1);
        for (int i = 0; i < DEPTH; i++)
            send_item(pcqda_pkg::OP_ENQ, 6'd63, 40'(i * 7));
        send_item(pcqda_pkg::OP_ENQ, 6'd63, 40'd0);
        send_item(pcqda_pkg::OP_DEQ, 6'd63, '1);
        send_item(pcqda_pkg::OP_DEQ, 6'd63, 40'd3);
        send_item(pcqda_pkg::OP_ENQ, 6'd0, '1);
        send_item(pcqda_pkg::OP_DEQ, 6'd0, 40'd0);
        send_item(pcqda_pkg::OP_END, 6'd17, '1);
        send_item(pcqda_pkg::OP_QUERY, 6'd63, 40'd0);
        send_item(pcqda_pkg::OP_QUERY, 6'd0, 40'd0);
        send_item(pcqda_pkg::OP_END, 6'd0, 40'd0);
        send_item(pcqda_pkg::OP_QUERY, 6'd63, 40'd0);

        // random: mostly enqueues and dequeues, mostly on a few busy classes
        n = 0;
        while (n < 600)
        begin
            if (n % 100 == 0)
                stall_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                c = $urandom_range(0, 63);
            else
                c = $urandom_range(0, 3);
            case ($urandom_range(0, 99)) inside
                [0:44]:  send_item(pcqda_pkg::OP_ENQ, 6'(c), next_time());
                [45:89]: send_item(pcqda_pkg::OP_DEQ, 6'(c), next_time());
                [90:96]: send_item(pcqda_pkg::OP_QUERY, 6'(c), 40'({$urandom, $urandom}));
                default: send_item(pcqda_pkg::OP_END, 6'(c), 40'({$urandom, $urandom}));
            endcase
            n++;
        end
        send_item(pcqda_pkg::OP_END, 6'd0, '0);
        for (int k = 0; k < N_CLASS; k++)
            send_item(pcqda_pkg::OP_QUERY, 6'(k), '0);
        req_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_per_class_queue_delay_averager_unit: PASS");
        else
            $display("tb_per_class_queue_delay_averager_unit: FAIL");
        $finish;
    end
endmodule
